### rtl/stwa_pkg.sv
// Shared types and constants for the spot table with aging.
// Used by stwa_cell and spot_table_with_aging_core.
package stwa_pkg;

   localparam int BANDS_DEF   = 16;
   localparam int ENTRIES_DEF = 256;
   localparam int KEY_W       = 60;
   localparam int FREQ_W      = 32;
   localparam int TIME_W      = 32;
   localparam int MODE_W      = 4;
   localparam int TOL_W       = 16;
   localparam int LIFE_W      = 10;
   localparam int LIMIT_W     = 16;
   localparam int COUNT_W     = 9;
   localparam int INDEX_W     = 8;
   localparam int CSR_IDX_W   = 2;
   localparam logic [LIMIT_W-1:0] SECS_PER_MIN = 16'd60;

   typedef enum logic [2:0] {
      OP_UPDATE = 3'd0,
      OP_SCAN   = 3'd1,
      OP_AGE    = 3'd2,
      OP_DELETE = 3'd3,
      OP_LOOKUP = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_BAND  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOL  = 2'd0,
      CSR_LIFE = 2'd1,
      CSR_OWN  = 2'd2
   } csr_type;

   // request-wide values, held for the whole pass
   typedef struct packed {
      op_type               op;
      logic [KEY_W-1:0]     key;
      logic [FREQ_W-1:0]    freq;
      logic [MODE_W-1:0]    mode;
      logic [TIME_W-1:0]    now;
      logic [KEY_W-1:0]     own;
      logic [TOL_W-1:0]     tol;
      logic [LIMIT_W-1:0]   limit;
   } ctl_type;

   // running result handed from cell to cell
   typedef struct packed {
      logic                 hit;
      logic                 free;
      logic [COUNT_W-1:0]   count;
   } acc_type;

endpackage

### rtl/spot_table_with_aging_core.sv
// Top level of the spot table with aging: control, registers and the cell row.
// Uses stwa_pkg and stwa_cell.
//
// Requests enter on req_* (valid/stall), one result leaves per request on rsp_*.
// Settings are to be written on csr_* while the block is idle; the block itself
// does not enforce this, and there is no read-back.
// Request ops: update, on-frequency scan, age-out, delete, lookup for one band.
// Each slot position of a band lives in one cell; a token walks the cell row,
// one cell per cycle, carrying the first match, the first free slot and count.
// A good request passes a memory read, the walk and the result load; an update
// that writes adds a write step before the result load; a bad band or op goes
// straight to the result load.
// Only one request is in work at a time: req_stall stays high until it is done.
// A new request may be taken while the previous result waits on rsp_stall.
// A result stalled by the receiver holds; the next result waits behind it.
// After reset the block runs a clearing pass over the band addresses that
// empties every slot of every band; req_stall stays high during it.
// Settings reset to tolerance 0, life 20 minutes, own key 0.
module spot_table_with_aging_core
   import stwa_pkg::*;
#(
   parameter int BANDS   = BANDS_DEF,
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_op,
   input  logic [3:0]             req_band,
   input  logic [KEY_W-1:0]       req_station_key,
   input  logic [FREQ_W-1:0]      req_frequency,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [TIME_W-1:0]      req_now_time,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [INDEX_W-1:0]     rsp_index,
   output logic                   rsp_was_new,
   output logic [COUNT_W-1:0]     rsp_occupied_count,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [KEY_W-1:0]       csr_data
);

   localparam int ADDR_W = (BANDS > 2) ? $clog2(BANDS-1) : 1;
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(BANDS - 2);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_READ  = 6'b000100,
      S_RUN   = 6'b001000,
      S_WRITE = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff;
   logic [ADDR_W-1:0]   band_addr_ff;
   logic [ADDR_W-1:0]   addr;
   ctl_type             ctl_ff;
   logic                go0_ff;

   logic [TOL_W-1:0]    tol_ff;
   logic [LIFE_W-1:0]   life_ff;
   logic [KEY_W-1:0]    own_ff;

   status_type          res_status_ff;
   logic [INDEX_W-1:0]  res_index_ff;
   logic                res_new_ff;
   logic [COUNT_W-1:0]  res_count_ff;
   logic [IDX_W-1:0]    wr_slot_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic                rsp_new_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                accept, op_bad, band_bad, rsp_free;

   // chain wiring: element i feeds cell i, element ENTRIES is the row's end
   logic                go_c       [ENTRIES+1];
   acc_type             acc_c      [ENTRIES+1];
   logic [IDX_W-1:0]    hit_idx_c  [ENTRIES+1];
   logic [IDX_W-1:0]    free_idx_c [ENTRIES+1];
   acc_type             last_acc;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign op_bad   = (req_op > OP_LOOKUP);
   assign band_bad = (req_band == 4'd0) || (32'(req_band) >= 32'(BANDS));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign addr     = (state_ff == S_CLEAR) ? clr_cnt_ff : band_addr_ff;
   assign last_acc = acc_c[ENTRIES];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_cnt_ff == ADDR_LAST) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) state_in = (op_bad || band_bad) ? S_FIN : S_READ;
         end
         S_READ: state_in = S_RUN;
         S_RUN: begin
            if (go_c[ENTRIES]) begin
               if ((ctl_ff.op == OP_UPDATE) && (last_acc.hit || last_acc.free))
                  state_in = S_WRITE;
               else
                  state_in = S_FIN;
            end
         end
         S_WRITE: state_in = S_FIN;
         S_FIN: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == S_FIN) && rsp_free) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         go0_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= '0;
         life_ff      <= LIFE_W'(20);
         own_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         go0_ff       <= (state_ff == S_READ);
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_CLEAR) clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         if (csr_write_en) begin
            case (csr_index)
               CSR_TOL:  tol_ff  <= csr_data[TOL_W-1:0];
               CSR_LIFE: life_ff <= csr_data[LIFE_W-1:0];
               CSR_OWN:  own_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff.op    <= op_type'(req_op);
         ctl_ff.key   <= req_station_key;
         ctl_ff.freq  <= req_frequency;
         ctl_ff.mode  <= req_mode;
         ctl_ff.now   <= req_now_time;
         ctl_ff.own   <= own_ff;
         ctl_ff.tol   <= tol_ff;
         ctl_ff.limit <= LIMIT_W'(life_ff) * SECS_PER_MIN;
         band_addr_ff <= ADDR_W'(req_band - 4'd1);
         res_index_ff <= '0;
         res_new_ff   <= 1'b0;
         res_count_ff <= '0;
         res_status_ff <= op_bad ? ST_NOT_FOUND : ST_BAD_BAND;
      end
      if ((state_ff == S_RUN) && go_c[ENTRIES]) begin
         case (ctl_ff.op)
            OP_UPDATE: begin
               if (last_acc.hit) begin
                  res_status_ff <= ST_OK;
                  res_index_ff  <= INDEX_W'(hit_idx_c[ENTRIES]);
                  wr_slot_ff    <= hit_idx_c[ENTRIES];
               end else if (last_acc.free) begin
                  res_status_ff <= ST_OK;
                  res_index_ff  <= INDEX_W'(free_idx_c[ENTRIES]);
                  res_new_ff    <= 1'b1;
                  wr_slot_ff    <= free_idx_c[ENTRIES];
               end else begin
                  res_status_ff <= ST_FULL;
               end
            end
            OP_AGE: begin
               res_status_ff <= ST_OK;
               res_count_ff  <= last_acc.count;
            end
            default: begin
               if (last_acc.hit) begin
                  res_status_ff <= ST_OK;
                  res_index_ff  <= INDEX_W'(hit_idx_c[ENTRIES]);
               end else begin
                  res_status_ff <= ST_NOT_FOUND;
               end
            end
         endcase
      end
      if ((state_ff == S_FIN) && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_new_ff    <= res_new_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   assign go_c[0]       = go0_ff;
   assign acc_c[0]      = '0;
   assign hit_idx_c[0]  = '0;
   assign free_idx_c[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      stwa_cell #(
         .BANDS    (BANDS),
         .ENTRIES  (ENTRIES),
         .CELL_IDX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl_ff),
         .addr         (addr),
         .rd_en        (state_ff == S_READ),
         .clr_en       (state_ff == S_CLEAR),
         .wr_en        (state_ff == S_WRITE),
         .wr_slot      (wr_slot_ff),
         .go_in        (go_c[i]),
         .acc_in       (acc_c[i]),
         .hit_idx_in   (hit_idx_c[i]),
         .free_idx_in  (free_idx_c[i]),
         .go_out       (go_c[i+1]),
         .acc_out      (acc_c[i+1]),
         .hit_idx_out  (hit_idx_c[i+1]),
         .free_idx_out (free_idx_c[i+1])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_index          = rsp_index_ff;
   assign rsp_was_new        = rsp_new_ff;
   assign rsp_occupied_count = rsp_count_ff;

endmodule

### rtl/stwa_cell.sv
// One slot position of the table: holds that slot for every band and
// updates the running result as the scan token passes. Uses stwa_pkg.
module stwa_cell
   import stwa_pkg::*;
#(
   parameter int BANDS    = BANDS_DEF,
   parameter int ENTRIES  = ENTRIES_DEF,
   parameter int CELL_IDX = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ctl_type                               ctl,
   input  logic [((BANDS > 2) ? $clog2(BANDS-1) : 1)-1:0] addr,
   input  logic                                  rd_en,
   input  logic                                  clr_en,
   input  logic                                  wr_en,
   input  logic [$clog2(ENTRIES)-1:0]            wr_slot,
   input  logic                                  go_in,
   input  acc_type                               acc_in,
   input  logic [$clog2(ENTRIES)-1:0]            hit_idx_in,
   input  logic [$clog2(ENTRIES)-1:0]            free_idx_in,
   output logic                                  go_out,
   output acc_type                               acc_out,
   output logic [$clog2(ENTRIES)-1:0]            hit_idx_out,
   output logic [$clog2(ENTRIES)-1:0]            free_idx_out
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int DEPTH  = BANDS - 1;
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [KEY_W-1:0]  key_mem  [DEPTH];
   logic [FREQ_W-1:0] freq_mem [DEPTH];
   logic [TIME_W-1:0] time_mem [DEPTH];
   logic [MODE_W-1:0] mode_mem [DEPTH];
   logic              mark_mem [DEPTH];

   logic [KEY_W-1:0]  rd_key_ff;
   logic [FREQ_W-1:0] rd_freq_ff;
   logic [TIME_W-1:0] rd_time_ff;

   logic              go_ff;
   acc_type           acc_ff, acc_in_nx;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in_nx;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in_nx;

   logic              key_we, data_we, mark_we, mark_wd;
   logic [KEY_W-1:0]  key_wd;
   logic              occupied, near, old;
   logic [FREQ_W-1:0] freq_gap;

   assign occupied = (rd_key_ff != '0);
   assign freq_gap = (rd_freq_ff >= ctl.freq) ? (rd_freq_ff - ctl.freq)
                                              : (ctl.freq - rd_freq_ff);
   assign near = (freq_gap < {{(FREQ_W-TOL_W){1'b0}}, ctl.tol});
   // age is signed: a stamp in the future never ages out
   assign old = (ctl.now > rd_time_ff) &&
                ((ctl.now - rd_time_ff) > {{(TIME_W-LIMIT_W){1'b0}}, ctl.limit});

   always_comb begin
      acc_in_nx      = acc_in;
      hit_idx_in_nx  = hit_idx_in;
      free_idx_in_nx = free_idx_in;
      key_we  = 1'b0;
      key_wd  = '0;
      data_we = 1'b0;
      mark_we = 1'b0;
      mark_wd = 1'b0;
      if (clr_en) begin
         key_we  = 1'b1;
         mark_we = 1'b1;
      end else if (wr_en && (wr_slot == MY_IDX)) begin
         key_we  = 1'b1;
         key_wd  = ctl.key;
         data_we = 1'b1;
      end else if (go_in) begin
         case (ctl.op)
            OP_UPDATE: begin
               if (!occupied) begin
                  if (!acc_in.free) begin
                     acc_in_nx.free = 1'b1;
                     free_idx_in_nx = MY_IDX;
                  end
               end else if (!acc_in.hit && (rd_key_ff == ctl.key)) begin
                  acc_in_nx.hit = 1'b1;
                  hit_idx_in_nx = MY_IDX;
               end
            end
            OP_SCAN: begin
               if (occupied && (rd_key_ff != ctl.own)) begin
                  mark_we = 1'b1;
                  mark_wd = near;
                  if (near && !acc_in.hit) begin
                     acc_in_nx.hit = 1'b1;
                     hit_idx_in_nx = MY_IDX;
                  end
               end
            end
            OP_AGE: begin
               if (occupied) begin
                  acc_in_nx.count = acc_in.count + COUNT_W'(1);
                  key_we = old;
               end
            end
            OP_DELETE, OP_LOOKUP: begin
               if ((ctl.key != '0) && !acc_in.hit && (rd_key_ff == ctl.key)) begin
                  acc_in_nx.hit = 1'b1;
                  hit_idx_in_nx = MY_IDX;
                  key_we = (ctl.op == OP_DELETE);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff  <= key_mem[addr];
         rd_freq_ff <= freq_mem[addr];
         rd_time_ff <= time_mem[addr];
      end
      if (key_we) key_mem[addr] <= key_wd;
      if (data_we) begin
         freq_mem[addr] <= ctl.freq;
         time_mem[addr] <= ctl.now;
         mode_mem[addr] <= ctl.mode;
      end
      if (mark_we) mark_mem[addr] <= mark_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= go_in;
      end
      acc_ff      <= acc_in_nx;
      hit_idx_ff  <= hit_idx_in_nx;
      free_idx_ff <= free_idx_in_nx;
   end

   assign go_out       = go_ff;
   assign acc_out      = acc_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule

### tb/sv/spot_table_checker.sv
// Checker for spot_table_with_aging_core: watches the request, result and register ports,
// predicts each result from its own copy of the band tables and compares field by field.
// Depends on stwa_pkg.
module spot_table_checker
   import stwa_pkg::*;
#(
   parameter int BANDS   = BANDS_DEF,
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [2:0]             req_op,
   input  logic [3:0]             req_band,
   input  logic [KEY_W-1:0]       req_station_key,
   input  logic [FREQ_W-1:0]      req_frequency,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [TIME_W-1:0]      req_now_time,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_status,
   input  logic [INDEX_W-1:0]     rsp_index,
   input  logic                   rsp_was_new,
   input  logic [COUNT_W-1:0]     rsp_occupied_count,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [KEY_W-1:0]       csr_data,
   output int                     errors,
   output int                     pending
);

   localparam int SLOTS = BANDS * ENTRIES;

   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   index;
      logic                 was_new;
      logic [COUNT_W-1:0]   count;
   } spot_result_type;

   logic [KEY_W-1:0]  key_mem  [SLOTS];
   logic [FREQ_W-1:0] freq_mem [SLOTS];
   logic [TIME_W-1:0] time_mem [SLOTS];
   logic [MODE_W-1:0] mode_mem [SLOTS];
   logic              mark_mem [SLOTS];

   logic [TOL_W-1:0]  tol_cfg;
   logic [LIFE_W-1:0] life_cfg;
   logic [KEY_W-1:0]  own_cfg;

   spot_result_type due_q[$];

   initial errors = 0;

   function automatic spot_result_type serve_request(input logic [2:0] op,
         input logic [3:0] band,
         input logic [KEY_W-1:0] key, input logic [FREQ_W-1:0] freq,
         input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] now);
      spot_result_type r;
      int base, slot, free_slot, cnt;
      bit found, have_free;
      logic [FREQ_W-1:0] d;
      longint age, limit;
      r = '{status: ST_OK, index: '0, was_new: 1'b0, count: '0};
      found = 0;
      have_free = 0;
      slot = 0;
      free_slot = 0;
      cnt = 0;
      if (op > OP_LOOKUP) begin
         r.status = ST_NOT_FOUND;
         return r;
      end
      if (band == 0 || band >= BANDS) begin
         r.status = ST_BAD_BAND;
         return r;
      end
      base = (band - 1) * ENTRIES;
      case (op_type'(op))
         OP_UPDATE: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (key_mem[base+i] == '0) begin
                  if (!have_free) begin
                     have_free = 1;
                     free_slot = i;
                  end
               end else if (!found && key_mem[base+i] == key) begin
                  found = 1;
                  slot = i;
               end
            end
            if (!found && !have_free) begin
               r.status = ST_FULL;
               return r;
            end
            if (!found) begin
               slot = free_slot;
               r.was_new = 1'b1;
            end
            // a zero key lands in the free slot but leaves it empty
            key_mem[base+slot]  = key;
            freq_mem[base+slot] = freq;
            time_mem[base+slot] = now;
            mode_mem[base+slot] = mode;
            r.index = slot[INDEX_W-1:0];
         end
         OP_SCAN: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (key_mem[base+i] == '0 || key_mem[base+i] == own_cfg) continue;
               d = (freq_mem[base+i] >= freq) ? freq_mem[base+i] - freq
                                              : freq - freq_mem[base+i];
               mark_mem[base+i] = (d < {16'b0, tol_cfg});
               if (mark_mem[base+i] && !found) begin
                  found = 1;
                  slot = i;
               end
            end
            if (found) r.index = slot[INDEX_W-1:0];
            else r.status = ST_NOT_FOUND;
         end
         OP_AGE: begin
            limit = 60 * longint'(life_cfg);
            for (int i = 0; i < ENTRIES; i++) begin
               if (key_mem[base+i] == '0) continue;
               // signed age: stamps in the future never expire
               age = longint'({32'b0, now}) - longint'({32'b0, time_mem[base+i]});
               if (age > limit) key_mem[base+i] = '0;
               cnt++;
            end
            r.count = cnt[COUNT_W-1:0];
         end
         default: begin
            r.status = ST_NOT_FOUND;
            if (key != '0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (key_mem[base+i] == key) begin
                     if (op_type'(op) == OP_DELETE) key_mem[base+i] = '0;
                     r.status = ST_OK;
                     r.index = i[INDEX_W-1:0];
                     break;
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      spot_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            key_mem[i] = '0;
            mark_mem[i] = 1'b0;
         end
         tol_cfg = '0;
         life_cfg = 10'd20;
         own_cfg = '0;
         due_q.delete();
      end else begin
         // results first: a beat accepted now cannot answer a request taken now
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               report_mismatch("unexpected result beat, status", rsp_status, -1);
            end else begin
               want = due_q.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_index != want.index)
                  report_mismatch("index", rsp_index, want.index);
               if (rsp_was_new != want.was_new)
                  report_mismatch("was_new", rsp_was_new, want.was_new);
               if (rsp_occupied_count != want.count)
                  report_mismatch("occupied_count", rsp_occupied_count, want.count);
            end
         end
         if (req_valid && !req_stall)
            due_q.push_back(serve_request(req_op, req_band, req_station_key, req_frequency,
                                          req_mode, req_now_time));
         if (csr_write_en) begin
            case (csr_type'(csr_index))
               CSR_TOL:  tol_cfg  = csr_data[TOL_W-1:0];
               CSR_LIFE: life_cfg = csr_data[LIFE_W-1:0];
               CSR_OWN:  own_cfg  = csr_data;
               default: ;
            endcase
         end
      end
      pending <= due_q.size();
   end

endmodule

### tb/sv/tb_spot_table_with_aging_core.sv
// Testbench top for spot_table_with_aging_core: clock, reset, request and register stimulus
// with random idling on both channels; the verdict comes from spot_table_checker.
// Depends on stwa_pkg, spot_table_with_aging_core and spot_table_checker.
module tb_spot_table_with_aging_core;
   import stwa_pkg::*;

   localparam int ENTRIES = ENTRIES_DEF;
   localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
   localparam logic [FREQ_W-1:0] BASE_FREQ = 32'd7_000_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_op = '0;
   logic [3:0]           req_band = '0;
   logic [KEY_W-1:0]     req_station_key = '0;
   logic [FREQ_W-1:0]    req_frequency = '0;
   logic [MODE_W-1:0]    req_mode = '0;
   logic [TIME_W-1:0]    req_now_time = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [INDEX_W-1:0]   rsp_index;
   logic                 rsp_was_new;
   logic [COUNT_W-1:0]   rsp_occupied_count;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [KEY_W-1:0]     csr_data = '0;
   int                   errors;
   int                   pending;

   bit                   calm = 1'b0;
   logic [KEY_W-1:0]     call_pool[12];
   logic [TIME_W-1:0]    clock_secs = 32'd100_000;

   spot_table_with_aging_core dut (.*);

   spot_table_checker checker_i (.*);

   initial forever #1 clock = ~clock;

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock)
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);

   task automatic put_req(input logic [2:0] op, input logic [3:0] band,
         input logic [KEY_W-1:0] key, input logic [FREQ_W-1:0] freq,
         input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] now);
      while (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_band        <= band;
      req_station_key <= key;
      req_frequency   <= freq;
      req_mode        <= mode;
      req_now_time    <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input logic [KEY_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [TOL_W-1:0] tol, input logic [LIFE_W-1:0] life,
         input logic [KEY_W-1:0] own);
      write_csr(CSR_TOL, {44'b0, tol});
      write_csr(CSR_LIFE, {50'b0, life});
      write_csr(CSR_OWN, own);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // sender holds off until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] any_key();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[KEY_W-1:0];
   endfunction

   function automatic logic [KEY_W-1:0] pick_call();
      int roll;
      roll = $urandom_range(99);
      if (roll < 75) return call_pool[$urandom_range(11)];
      if (roll < 83) return '0;
      return any_key();
   endfunction

   task automatic random_beat();
      int roll;
      logic [2:0] op;
      logic [3:0] band;
      logic [FREQ_W-1:0] freq;
      roll = $urandom_range(99);
      if (roll < 40) op = OP_UPDATE;
      else if (roll < 55) op = OP_SCAN;
      else if (roll < 68) op = OP_AGE;
      else if (roll < 80) op = OP_DELETE;
      else if (roll < 95) op = OP_LOOKUP;
      else op = 3'($urandom_range(5, 7));
      band = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 3));
      freq = ($urandom_range(9) == 0) ? $urandom : BASE_FREQ + $urandom_range(400);
      roll = $urandom_range(99);
      if (roll < 80) clock_secs = clock_secs + $urandom_range(300);
      else if (roll < 90) clock_secs = clock_secs - $urandom_range(2000);
      put_req(op, band, pick_call(), freq, 4'($urandom_range(15)),
              (roll >= 95) ? $urandom : clock_secs);
   endtask

   initial begin
      for (int i = 0; i < 12; i++) call_pool[i] = any_key();
      call_pool[0] = KEY_MAX;
      call_pool[1] = 60'd1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values
      put_req(OP_UPDATE, 4'd1, call_pool[2], BASE_FREQ, 4'd0, 32'd1000);
      put_req(OP_UPDATE, 4'd1, call_pool[2], BASE_FREQ + 5, 4'd3, 32'd1100);
      put_req(OP_UPDATE, 4'd1, KEY_MAX, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
      put_req(OP_UPDATE, 4'd1, '0, 32'd0, 4'd0, 32'd0);
      put_req(OP_UPDATE, 4'd0, call_pool[3], BASE_FREQ, 4'd1, 32'd5);
      put_req(OP_UPDATE, 4'd15, call_pool[3], BASE_FREQ, 4'd1, 32'd5);
      put_req(3'd5, 4'd1, call_pool[2], BASE_FREQ, 4'd0, 32'd0);
      put_req(3'd6, 4'd1, call_pool[2], BASE_FREQ, 4'd0, 32'd0);
      put_req(3'd7, 4'd1, call_pool[2], BASE_FREQ, 4'd0, 32'd0);
      put_req(OP_SCAN, 4'd1, '0, BASE_FREQ, 4'd0, 32'd0);
      put_req(OP_LOOKUP, 4'd1, call_pool[2], 32'd0, 4'd0, 32'd0);
      put_req(OP_LOOKUP, 4'd15, call_pool[3], 32'd0, 4'd0, 32'd0);
      put_req(OP_LOOKUP, 4'd1, '0, 32'd0, 4'd0, 32'd0);
      put_req(OP_DELETE, 4'd1, call_pool[2], 32'd0, 4'd0, 32'd0);
      put_req(OP_DELETE, 4'd1, call_pool[2], 32'd0, 4'd0, 32'd0);
      put_req(OP_DELETE, 4'd1, '0, 32'd0, 4'd0, 32'd0);
      put_req(OP_AGE, 4'd1, '0, 32'd0, 4'd0, 32'd0);
      put_req(OP_AGE, 4'd1, '0, 32'd0, 4'd0, 32'hFFFF_FFFF);
      put_req(OP_AGE, 4'd0, '0, 32'd0, 4'd0, 32'd0);
      drain();

      set_regs(16'hFFFF, 10'd1023, call_pool[4]);
      put_req(OP_UPDATE, 4'd2, call_pool[4], BASE_FREQ, 4'd2, clock_secs);
      put_req(OP_SCAN, 4'd2, '0, BASE_FREQ, 4'd0, 32'd0);
      repeat (200) random_beat();
      drain();

      // no idling on either side through this phase
      calm = 1'b1;
      set_regs(16'd0, 10'd0, KEY_MAX);
      repeat (100) random_beat();
      drain();
      calm = 1'b0;

      set_regs(16'd300, 10'd5, call_pool[1]);
      // fill one band past capacity, then age the whole band out
      for (int i = 0; i < ENTRIES + 4; i++)
         put_req(OP_UPDATE, 4'd4, {48'hABC, 12'(i)}, BASE_FREQ + i, 4'(i), clock_secs);
      put_req(OP_SCAN, 4'd4, '0, BASE_FREQ + 100, 4'd0, 32'd0);
      put_req(OP_AGE, 4'd4, '0, 32'd0, 4'd0, clock_secs + 32'd301);
      put_req(OP_LOOKUP, 4'd4, {48'hABC, 12'd7}, 32'd0, 4'd0, 32'd0);
      repeat (90) random_beat();
      drain();

      repeat (ENTRIES + 20) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
